// ----- sv/tlec_pkg.sv -----
`default_nettype none
package tlec_pkg;

    localparam int ADDR_BITS_DEF   = 48;
    localparam int L1_MAX_SETS_DEF = 64;
    localparam int L1_MAX_WAYS_DEF = 8;
    localparam int L2_MAX_SETS_DEF = 256;
    localparam int L2_MAX_WAYS_DEF = 16;
    localparam int AGE_BITS_DEF    = 32;

    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = 5;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_L1_SETS_LOG2 = 3'd0,
        CFG_L1_WAYS      = 3'd1,
        CFG_L1_LRU       = 3'd2,
        CFG_L2_SETS_LOG2 = 3'd3,
        CFG_L2_WAYS      = 3'd4,
        CFG_LINE_LOG2    = 3'd5
    } cfg_idx_t;

    typedef struct packed {
        logic                     cmd;
        logic [ADDR_BITS_DEF-1:0] address;
    } req_t;

    typedef struct packed {
        logic l1_hit;
        logic l2_hit;
        logic mem_read;
        logic mem_write;
        logic l1_victim_moved;
        logic l2_victim_dropped;
    } resp_t;

    // command from the sequencer to a cache level
    typedef enum logic [1:0] {
        LOP_PROBE = 2'd0,   // find matching way, record victim and max age
        LOP_TOUCH = 2'd1,   // set age of the hit way to max+1
        LOP_INVAL = 2'd2,   // invalidate the hit way
        LOP_FILL  = 2'd3    // write tag into the victim way
    } lop_t;

    typedef struct packed {
        logic start;
        lop_t op;
    } lvl_ctl_t;

    typedef struct packed {
        logic done;
        logic hit;
        logic displaced;
    } lvl_sts_t;

endpackage
`default_nettype wire

// ----- sv/tlec_level.sv -----
`default_nettype none
// One cache level. Ways of a set are walked one at a time, each with a read
// step and a compare step, through a single compare/age unit; tags, ages and
// valid bits sit in memories, ages and valid bits swept clear after reset.
module tlec_level
    import tlec_pkg::*;
#(
    parameter int ADDR_BITS = ADDR_BITS_DEF,
    parameter int MAX_SETS  = L1_MAX_SETS_DEF,
    parameter int MAX_WAYS  = L1_MAX_WAYS_DEF,
    parameter int AGE_BITS  = AGE_BITS_DEF,
    localparam int SET_BITS = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1,
    localparam int WAY_BITS = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1,
    localparam int WCNT_BITS = $clog2(MAX_WAYS + 1),
    localparam int DEPTH    = MAX_SETS * MAX_WAYS,
    localparam int IDX_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire lvl_ctl_t             ctl,
    input  wire logic [SET_BITS-1:0]  set_idx,
    input  wire logic [ADDR_BITS-1:0] tag,
    input  wire logic [WCNT_BITS-1:0] ways,
    output lvl_sts_t                  sts,
    output logic [ADDR_BITS-1:0]      old_tag,
    output logic                      clr_busy
);

    typedef enum logic [2:0] {S_CLR, S_IDLE, S_RD, S_CMP, S_WR} state_t;

    localparam logic [AGE_BITS-1:0] AGE_MAX = '1;

    logic [ADDR_BITS-1:0] tag_mem [DEPTH];
    logic [AGE_BITS-1:0]  age_mem [DEPTH];
    logic                 val_mem [DEPTH];

    state_t               state_reg;
    lop_t                 op_reg;
    logic [WAY_BITS-1:0]  way_reg;
    logic [WAY_BITS-1:0]  hit_way_reg, pick_reg;
    logic                 hit_reg, inv_found_reg;
    logic [AGE_BITS-1:0]  max_reg, min_reg;
    logic [ADDR_BITS-1:0] old_tag_reg;
    logic                 disp_reg, done_reg;
    logic [IDX_BITS-1:0]  clr_reg;

    logic [ADDR_BITS-1:0] rd_tag_reg;
    logic [AGE_BITS-1:0]  rd_age_reg;
    logic                 rd_val_reg;

    logic [IDX_BITS-1:0]  base_idx, rd_idx, wr_idx;
    logic                 last_way;

    assign base_idx = IDX_BITS'(set_idx) * IDX_BITS'(MAX_WAYS);
    assign rd_idx   = base_idx + IDX_BITS'(way_reg);
    assign last_way = (WCNT_BITS'(way_reg) + WCNT_BITS'(1)) >= ways;
    assign wr_idx   = base_idx + IDX_BITS'((op_reg == LOP_FILL) ? pick_reg : hit_way_reg);

    logic [AGE_BITS-1:0] next_age;
    assign next_age = (max_reg == AGE_MAX) ? AGE_MAX : max_reg + AGE_BITS'(1);

    always_ff @(posedge aclk) begin
        rd_tag_reg <= tag_mem[rd_idx];
        rd_age_reg <= age_mem[rd_idx];
        if (state_reg == S_WR && op_reg == LOP_FILL)
            tag_mem[wr_idx] <= tag;
        if (state_reg == S_CLR)
            age_mem[clr_reg] <= '0;
        else if (state_reg == S_WR)
            age_mem[wr_idx] <= (op_reg == LOP_INVAL) ? '0 : next_age;
    end

    always_ff @(posedge aclk) begin
        if (state_reg == S_CLR)
            val_mem[clr_reg] <= 1'b0;
        else if (state_reg == S_WR && op_reg == LOP_FILL)
            val_mem[wr_idx] <= 1'b1;
        else if (state_reg == S_WR && op_reg == LOP_INVAL)
            val_mem[wr_idx] <= 1'b0;
        rd_val_reg <= val_mem[rd_idx];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_CLR;
            clr_reg   <= '0;
            done_reg  <= 1'b0;
            way_reg   <= '0;
            op_reg    <= LOP_PROBE;
        end else begin
            done_reg <= 1'b0;
            unique case (state_reg)
                S_CLR: begin
                    clr_reg <= clr_reg + IDX_BITS'(1);
                    if (clr_reg == IDX_BITS'(DEPTH - 1))
                        state_reg <= S_IDLE;
                end
                S_IDLE: begin
                    if (ctl.start) begin
                        op_reg <= ctl.op;
                        way_reg <= '0;
                        if (ctl.op == LOP_INVAL) begin
                            state_reg <= S_WR;
                        end else begin
                            state_reg <= S_RD;
                            hit_reg <= 1'b0;
                            inv_found_reg <= 1'b0;
                            pick_reg <= '0;
                        end
                    end
                end
                S_RD: state_reg <= S_CMP;
                S_CMP: begin
                    // one way per step: match, first invalid, min and max age
                    if (way_reg == '0) begin
                        max_reg <= rd_age_reg;
                        min_reg <= rd_age_reg;
                    end else begin
                        if (rd_age_reg > max_reg)
                            max_reg <= rd_age_reg;
                        if (!inv_found_reg && rd_age_reg < min_reg) begin
                            min_reg  <= rd_age_reg;
                            pick_reg <= way_reg;
                        end
                    end
                    if (!inv_found_reg && !rd_val_reg) begin
                        inv_found_reg <= 1'b1;
                        pick_reg <= way_reg;
                    end
                    if (!hit_reg && rd_val_reg && rd_tag_reg == tag) begin
                        hit_reg     <= 1'b1;
                        hit_way_reg <= way_reg;
                    end
                    if (way_reg == pick_reg || (!inv_found_reg && !rd_val_reg)
                        || (way_reg != '0 && !inv_found_reg && rd_age_reg < min_reg)) begin
                        old_tag_reg <= rd_tag_reg;
                        disp_reg    <= rd_val_reg;
                    end
                    if (last_way) begin
                        state_reg <= (op_reg == LOP_PROBE) ? S_IDLE : S_WR;
                        done_reg  <= (op_reg == LOP_PROBE);
                    end else begin
                        way_reg   <= way_reg + WAY_BITS'(1);
                        state_reg <= S_RD;
                    end
                end
                S_WR: begin
                    state_reg <= S_IDLE;
                    done_reg  <= 1'b1;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign sts.done      = done_reg;
    assign sts.hit       = hit_reg;
    assign sts.displaced = disp_reg;
    assign old_tag       = old_tag_reg;
    assign clr_busy      = (state_reg == S_CLR);

endmodule
`default_nettype wire

// ----- sv/two_level_exclusive_cache_model_unit.sv -----
`default_nettype none
// Two-level exclusive cache model: one beat in, one status beat out per access.
// Each level walks its ways one at a time through its own compare/age unit. An
// L1 hit goes from accept to result through the L1 probe, plus an L1 age update
// under LRU. A miss adds the L2 probe, the L2 invalidate on an L2 hit, the L1
// refill pass and, when the refill displaces a valid L1 line, the L2 victim
// insert pass. The result is held until m_ready. After reset both levels are
// swept clear, the L2 over its L2_MAX_SETS*L2_MAX_WAYS entries (4096 by
// default), during which no access is accepted.
module two_level_exclusive_cache_model_unit
    import tlec_pkg::*;
#(
    parameter int L1_MAX_SETS = L1_MAX_SETS_DEF,
    parameter int L1_MAX_WAYS = L1_MAX_WAYS_DEF,
    parameter int L2_MAX_SETS = L2_MAX_SETS_DEF,
    parameter int L2_MAX_WAYS = L2_MAX_WAYS_DEF,
    parameter int AGE_BITS    = AGE_BITS_DEF
) (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic                     cfg_we,
    input  wire logic [CFG_IDX_BITS-1:0]  cfg_index,
    input  wire logic [CFG_DATA_BITS-1:0] cfg_data,
    input  wire logic                     s_valid,
    output logic                          s_ready,
    input  wire req_t                     s_data,
    output logic                          m_valid,
    input  wire logic                     m_ready,
    output resp_t                         m_data
);

    localparam int ADDR_BITS = ADDR_BITS_DEF;
    localparam int S1B = (L1_MAX_SETS > 1) ? $clog2(L1_MAX_SETS) : 1;
    localparam int S2B = (L2_MAX_SETS > 1) ? $clog2(L2_MAX_SETS) : 1;
    localparam int W1C = $clog2(L1_MAX_WAYS + 1);
    localparam int W2C = $clog2(L2_MAX_WAYS + 1);
    localparam int L1_LOG_MAX = $clog2(L1_MAX_SETS);
    localparam int L2_LOG_MAX = $clog2(L2_MAX_SETS);

    typedef enum logic [3:0] {
        T_IDLE, T_P1, T_W1, T_P2, T_W2, T_INV, T_WI, T_F1, T_WF1, T_F2, T_WF2, T_OUT
    } state_t;

    state_t state_reg;

    logic [2:0] l1s_reg;
    logic [3:0] l1w_reg;
    logic       lru_reg;
    logic [3:0] l2s_reg;
    logic [4:0] l2w_reg;
    logic [3:0] lb_reg;

    logic [ADDR_BITS-1:0] addr_reg;
    logic                 cmd_reg;
    resp_t                out_reg;

    lvl_ctl_t ctl1, ctl2;
    lvl_sts_t sts1, sts2;
    logic [ADDR_BITS-1:0] otag1, otag2;
    logic busy1, busy2;

    // effective geometry
    logic [3:0] s1e, s2e;
    logic [W1C-1:0] w1e;
    logic [W2C-1:0] w2e;
    assign s1e = (32'(l1s_reg) > L1_LOG_MAX) ? 4'(L1_LOG_MAX) : 4'(l1s_reg);
    assign s2e = (32'(l2s_reg) > L2_LOG_MAX) ? 4'(L2_LOG_MAX) : 4'(l2s_reg);
    assign w1e = (l1w_reg == '0) ? W1C'(1) :
                 (32'(l1w_reg) > L1_MAX_WAYS) ? W1C'(L1_MAX_WAYS) : W1C'(l1w_reg);
    assign w2e = (l2w_reg == '0) ? W2C'(1) :
                 (32'(l2w_reg) > L2_MAX_WAYS) ? W2C'(L2_MAX_WAYS) : W2C'(l2w_reg);

    // L2 is keyed either by the request address or by the rebuilt victim address
    logic [ADDR_BITS-1:0] line_a, vaddr, a2;
    logic [ADDR_BITS-1:0] set1_full;
    logic [S1B-1:0] set1;
    logic [S2B-1:0] set2;
    logic [ADDR_BITS-1:0] tag1, tag2;
    logic use_victim;

    assign line_a    = addr_reg >> lb_reg;
    assign set1_full = line_a & ((ADDR_BITS'(1) << s1e) - ADDR_BITS'(1));
    assign set1      = S1B'(set1_full);
    assign tag1      = line_a >> s1e;
    assign vaddr     = (otag1 << (s1e + 5'(lb_reg))) | (set1_full << lb_reg);
    assign use_victim = (state_reg == T_F2 || state_reg == T_WF2);
    assign a2        = use_victim ? vaddr : addr_reg;
    assign set2      = S2B'((a2 >> lb_reg) & ((ADDR_BITS'(1) << s2e) - ADDR_BITS'(1)));
    assign tag2      = a2 >> (s2e + 5'(lb_reg));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            l1s_reg <= '0; l1w_reg <= 4'd1; lru_reg <= 1'b0;
            l2s_reg <= '0; l2w_reg <= 5'd1; lb_reg  <= 4'd4;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_L1_SETS_LOG2: l1s_reg <= cfg_data[2:0];
                CFG_L1_WAYS:      l1w_reg <= cfg_data[3:0];
                CFG_L1_LRU:       lru_reg <= cfg_data[0];
                CFG_L2_SETS_LOG2: l2s_reg <= cfg_data[3:0];
                CFG_L2_WAYS:      l2w_reg <= cfg_data[4:0];
                CFG_LINE_LOG2:    lb_reg  <= cfg_data[3:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        ctl1 = '{start: 1'b0, op: LOP_PROBE};
        ctl2 = '{start: 1'b0, op: LOP_PROBE};
        unique case (state_reg)
            T_P1:  ctl1 = '{start: 1'b1, op: LOP_PROBE};
            T_P2:  ctl2 = '{start: 1'b1, op: LOP_PROBE};
            T_INV: ctl2 = '{start: 1'b1, op: LOP_INVAL};
            T_F1:  ctl1 = '{start: 1'b1, op: LOP_FILL};
            T_F2:  ctl2 = '{start: 1'b1, op: LOP_FILL};
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= T_IDLE;
        end else begin
            unique case (state_reg)
                T_IDLE: if (s_valid && s_ready) begin
                    addr_reg  <= s_data.address;
                    cmd_reg   <= s_data.cmd;
                    out_reg   <= '0;
                    state_reg <= T_P1;
                end
                T_P1: state_reg <= T_W1;
                T_W1: if (sts1.done) begin
                    if (sts1.hit) begin
                        out_reg.l1_hit <= 1'b1;
                        state_reg <= lru_reg ? T_INV : T_OUT;
                    end else begin
                        state_reg <= T_P2;
                    end
                end
                T_P2: state_reg <= T_W2;
                T_W2: if (sts2.done) begin
                    out_reg.l2_hit   <= sts2.hit;
                    out_reg.mem_read <= !sts2.hit;
                    state_reg <= sts2.hit ? T_INV : T_F1;
                end
                T_INV: state_reg <= T_WI;
                T_WI: if (sts1.done || sts2.done)
                    state_reg <= out_reg.l1_hit ? T_OUT : T_F1;
                T_F1: state_reg <= T_WF1;
                T_WF1: if (sts1.done) begin
                    out_reg.l1_victim_moved <= sts1.displaced;
                    state_reg <= sts1.displaced ? T_F2 : T_OUT;
                end
                T_F2: state_reg <= T_WF2;
                T_WF2: if (sts2.done) begin
                    out_reg.l2_victim_dropped <= sts2.displaced;
                    state_reg <= T_OUT;
                end
                T_OUT: if (m_ready) state_reg <= T_IDLE;
                default: state_reg <= T_IDLE;
            endcase
        end
    end

    // on an L1 hit under LRU the T_INV slot touches L1 instead of L2
    lvl_ctl_t c1, c2;
    always_comb begin
        c1 = ctl1;
        c2 = ctl2;
        if (state_reg == T_INV && out_reg.l1_hit) begin
            c1 = '{start: 1'b1, op: LOP_TOUCH};
            c2 = '{start: 1'b0, op: LOP_PROBE};
        end
    end

    tlec_level #(
        .ADDR_BITS(ADDR_BITS), .MAX_SETS(L1_MAX_SETS), .MAX_WAYS(L1_MAX_WAYS),
        .AGE_BITS(AGE_BITS)
    ) u_l1 (
        .aclk, .aresetn, .ctl(c1), .set_idx(set1), .tag(tag1), .ways(w1e),
        .sts(sts1), .old_tag(otag1), .clr_busy(busy1)
    );

    tlec_level #(
        .ADDR_BITS(ADDR_BITS), .MAX_SETS(L2_MAX_SETS), .MAX_WAYS(L2_MAX_WAYS),
        .AGE_BITS(AGE_BITS)
    ) u_l2 (
        .aclk, .aresetn, .ctl(c2), .set_idx(set2), .tag(tag2), .ways(w2e),
        .sts(sts2), .old_tag(otag2), .clr_busy(busy2)
    );

    logic unused_sig;
    assign unused_sig = ^otag2;

    assign s_ready = (state_reg == T_IDLE) && !busy1 && !busy2;
    assign m_valid = (state_reg == T_OUT);
    always_comb begin
        m_data = out_reg;
        m_data.mem_write = cmd_reg;
    end

endmodule
`default_nettype wire
